[design/phnl_pkg.sv]
// ----------------------------------------------------------------------------
// phnl_pkg
// Shared types, codes and the hash mixing step for the name lookup block.
// ----------------------------------------------------------------------------
package phnl_pkg;

  localparam logic [63:0] HASH_PRIME = 64'h0000_0000_0100_0193;
  localparam int unsigned REM_W = 13;

  typedef enum logic [1:0] {
    FUNC_DISP   = 2'd0,
    FUNC_SLOT   = 2'd1,
    FUNC_KEY    = 2'd2,
    FUNC_LOOKUP = 2'd3
  } func_t;

  typedef struct packed {
    logic [1:0]         func;
    logic [7:0]         entry_index;
    logic [5:0]         byte_position;
    logic signed [31:0] displacement;
    logic [7:0]         slot_value;
    logic [7:0]         key_byte;
    logic               last;
  } in_word_t;

  typedef struct packed {
    logic        found;
    logic [7:0]  slot;
    logic [63:0] key_hash;
    logic        too_long;
  } out_word_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [REM_W-1:0] rem;
  } mod_res_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_M1GO,
    S_M1WAIT,
    S_DISP,
    S_DECIDE,
    S_RH_RD,
    S_RH_MIX,
    S_M2GO,
    S_M2WAIT,
    S_SLOT,
    S_LEN,
    S_KL,
    S_CMP_RD,
    S_CMP_CHK,
    S_DONE
  } state_t;

  // h = (h ^ sext(b)) * prime; prime = 2^24 + 2^8 + 2^7 + 2^4 + 2^1 + 1
  function automatic logic [63:0] phnl_mix(input logic [63:0] h, input logic [7:0] b);
    logic [63:0] x;
    x = h ^ {{56{b[7]}}, b};
    return (x << 24) + (x << 8) + (x << 7) + (x << 4) + (x << 1) + x;
  endfunction

endpackage

[design/phnl_mod.sv]
// ----------------------------------------------------------------------------
// phnl_mod
// Bit-serial remainder of a 64-bit hash by the table size, one bit a cycle.
// ----------------------------------------------------------------------------
module phnl_mod (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic [63:0]              dividend,
  input  logic [phnl_pkg::REM_W-1:0] divisor,
  output phnl_pkg::mod_res_t       res
);
  import phnl_pkg::*;

  logic [63:0]      dvd;
  logic [REM_W-1:0] rem;
  logic [REM_W-1:0] dsr;
  logic [6:0]       cnt;
  logic             busy;
  logic             done;
  logic [REM_W:0]   trial;

  assign trial = {rem, dvd[63]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= 7'd0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= 7'd64;
      end else if (busy) begin
        cnt <= cnt - 7'd1;
        if (cnt == 7'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd <= dividend;
      rem <= '0;
      dsr <= divisor;
    end else if (busy) begin
      dvd <= {dvd[62:0], 1'b0};
      if (trial >= {1'b0, dsr}) begin
        rem <= REM_W'(trial - {1'b0, dsr});
      end else begin
        rem <= trial[REM_W-1:0];
      end
    end
  end

  assign res.busy = busy;
  assign res.done = done;
  assign res.rem  = rem;

endmodule

[design/perfect_hash_name_lookup_top.sv]
// ----------------------------------------------------------------------------
// perfect_hash_name_lookup_top
// Two-level hash-and-displace lookup of a name against a loaded key table.
// ----------------------------------------------------------------------------
//
//   channel   direction  handshake           word
//   in        input      in_valid/in_ready   in_word_t (load or lookup byte)
//   out       output     out_valid/out_ready out_word_t (found, slot, hash)
//   cfg       input      cfg_we              cfg_wdata (table_size)
//
// Table writes and lookup bytes that are not final are taken back to back in
// S_IDLE. A final lookup byte starts a search paced by the passes of the
// bit-serial remainder unit (two on the rehash path, one on the direct path)
// and by byte-at-a-time buffer and key reads.
// Reset (rst, synchronous) clears control only; tables hold garbage until
// loaded. A result waiting on out_ready holds in its register while new
// words are taken; a second result waits in S_DONE.
module perfect_hash_name_lookup_top #(
  parameter int unsigned TABLE_DEPTH = 256,
  parameter int unsigned MAX_KEY_LEN = 64
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  phnl_pkg::in_word_t   in_word,
  output logic                 out_valid,
  input  logic                 out_ready,
  output phnl_pkg::out_word_t  out_word,
  input  logic                 cfg_we,
  input  logic [8:0]           cfg_wdata
);
  import phnl_pkg::*;

  localparam int unsigned IW  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned BW  = (MAX_KEY_LEN > 1) ? $clog2(MAX_KEY_LEN) : 1;
  localparam int unsigned LW  = $clog2(MAX_KEY_LEN + 1);
  localparam int unsigned KD  = TABLE_DEPTH * MAX_KEY_LEN;
  localparam int unsigned KAW = $clog2(KD);

  // Memories
  logic [31:0]   disp_mem [TABLE_DEPTH];
  logic [7:0]    slot_mem [TABLE_DEPTH];
  logic [7:0]    key_mem  [KD];
  logic [LW-1:0] klen_mem [TABLE_DEPTH];
  logic [7:0]    buf_mem  [MAX_KEY_LEN];

  state_t state, state_next;

  logic [8:0]       table_size;
  logic [REM_W-1:0] eff_n;
  logic [REM_W-1:0] ts_ext;

  logic [63:0]   running_hash;
  logic [LW-1:0] lookup_length;
  logic          overflow_flag;

  logic [63:0]   h2;
  logic [LW-1:0] idx;
  logic [IW-1:0] hidx;
  logic [IW-1:0] sidx;
  logic [7:0]    slot_r;
  logic          found_r;

  logic [31:0]   disp_q;
  logic [7:0]    slot_q;
  logic [LW-1:0] klen_q;
  logic [7:0]    key_q;
  logic [7:0]    buf_q;

  logic          accept;
  logic          is_lookup;
  logic          in_entry_ok;
  logic          last_ovf;
  logic          mod_start;
  logic [63:0]   mod_dvd;
  mod_res_t      mod_res;

  logic [31:0]   dir_idx;
  logic [31:0]   slot_ext;
  logic          slot_ok;
  logic [7:0]    cmp_a;
  logic [7:0]    cmp_b;
  logic [31:0]   key_waddr;
  logic [31:0]   key_raddr;

  assign in_ready  = (state == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign is_lookup = (in_word.func == FUNC_LOOKUP);
  assign in_entry_ok = (32'(in_word.entry_index) < 32'(TABLE_DEPTH));
  // The final byte overflows if the buffer was already full.
  assign last_ovf  = overflow_flag || (lookup_length == LW'(MAX_KEY_LEN));

  // Clamp the modulus into 1..TABLE_DEPTH.
  assign ts_ext = REM_W'(table_size);
  always_comb begin
    if (ts_ext == '0) begin
      eff_n = REM_W'(1);
    end else if (ts_ext > REM_W'(TABLE_DEPTH)) begin
      eff_n = REM_W'(TABLE_DEPTH);
    end else begin
      eff_n = ts_ext;
    end
  end

  assign dir_idx  = ~disp_q & 32'h7FFF_FFFF;
  assign slot_ext = {24'd0, slot_q};
  assign slot_ok  = (slot_ext < 32'(TABLE_DEPTH));
  assign cmp_a    = (idx < klen_q) ? key_q : 8'd0;
  assign cmp_b    = (idx < lookup_length) ? buf_q : 8'd0;
  assign key_waddr = 32'(in_word.entry_index) * 32'(MAX_KEY_LEN) + 32'(in_word.byte_position);
  assign key_raddr = 32'(slot_r) * 32'(MAX_KEY_LEN) + 32'(idx);

  phnl_mod u_mod (
    .clk      (clk),
    .rst      (rst),
    .start    (mod_start),
    .dividend (mod_dvd),
    .divisor  (eff_n),
    .res      (mod_res)
  );

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      table_size <= 9'd1;
    end else if (cfg_we) begin
      table_size <= cfg_wdata;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept && is_lookup && in_word.last) begin
          state_next = last_ovf ? S_DONE : S_M1GO;
        end
      end
      S_M1GO:   state_next = S_M1WAIT;
      S_M1WAIT: if (mod_res.done) state_next = S_DISP;
      S_DISP:   state_next = S_DECIDE;
      S_DECIDE: begin
        if (disp_q[31]) begin
          state_next = (dir_idx < 32'(TABLE_DEPTH)) ? S_SLOT : S_DONE;
        end else begin
          state_next = (lookup_length == '0) ? S_M2GO : S_RH_RD;
        end
      end
      S_RH_RD:  state_next = S_RH_MIX;
      S_RH_MIX: state_next = (idx + LW'(1) == lookup_length) ? S_M2GO : S_RH_RD;
      S_M2GO:   state_next = S_M2WAIT;
      S_M2WAIT: if (mod_res.done) state_next = S_SLOT;
      S_SLOT:   state_next = S_LEN;
      S_LEN:    state_next = slot_ok ? S_KL : S_DONE;
      S_KL:     state_next = S_CMP_RD;
      S_CMP_RD: state_next = S_CMP_CHK;
      S_CMP_CHK: begin
        if (cmp_a != cmp_b || cmp_a == 8'd0) begin
          state_next = S_DONE;
        end else begin
          state_next = S_CMP_RD;
        end
      end
      S_DONE:   if (!out_valid || out_ready) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  // Outputs of the sequencer
  always_comb begin
    mod_start = (state == S_M1GO) || (state == S_M2GO);
    mod_dvd   = (state == S_M2GO) ? h2 : running_hash;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Lookup state: hash, length, overflow
  always_ff @(posedge clk) begin
    if (rst) begin
      running_hash  <= HASH_PRIME;
      lookup_length <= '0;
      overflow_flag <= 1'b0;
    end else if (accept && is_lookup) begin
      running_hash <= phnl_mix(running_hash, in_word.key_byte);
      if (lookup_length < LW'(MAX_KEY_LEN)) begin
        lookup_length <= lookup_length + LW'(1);
      end else begin
        overflow_flag <= 1'b1;
      end
    end else if (state == S_DONE && (!out_valid || out_ready)) begin
      running_hash  <= HASH_PRIME;
      lookup_length <= '0;
      overflow_flag <= 1'b0;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: found_r <= 1'b0;
      S_M1WAIT: if (mod_res.done) hidx <= mod_res.rem[IW-1:0];
      S_DECIDE: begin
        sidx <= dir_idx[IW-1:0];
        idx  <= '0;
        h2   <= (disp_q == 32'd0) ? HASH_PRIME : {32'd0, disp_q};
      end
      S_RH_MIX: begin
        h2  <= phnl_mix(h2, buf_q);
        idx <= idx + LW'(1);
      end
      S_M2WAIT: if (mod_res.done) sidx <= mod_res.rem[IW-1:0];
      S_LEN: begin
        slot_r <= slot_q;
        idx    <= '0;
      end
      S_CMP_CHK: begin
        if (cmp_a != cmp_b) begin
          found_r <= 1'b0;
        end else if (cmp_a == 8'd0) begin
          found_r <= 1'b1;
        end else begin
          idx <= idx + LW'(1);
        end
      end
      default: begin
      end
    endcase
  end

  // Memory writes
  always_ff @(posedge clk) begin
    if (accept && in_entry_ok && in_word.func == FUNC_DISP) begin
      disp_mem[IW'(in_word.entry_index)] <= in_word.displacement;
    end
    disp_q <= disp_mem[hidx];
  end

  always_ff @(posedge clk) begin
    if (accept && in_entry_ok && in_word.func == FUNC_SLOT) begin
      slot_mem[IW'(in_word.entry_index)] <= in_word.slot_value;
    end
    slot_q <= slot_mem[sidx];
  end

  always_ff @(posedge clk) begin
    if (accept && in_entry_ok && in_word.func == FUNC_KEY &&
        32'(in_word.byte_position) < 32'(MAX_KEY_LEN)) begin
      key_mem[key_waddr[KAW-1:0]] <= in_word.key_byte;
    end
    key_q <= key_mem[key_raddr[KAW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (accept && in_entry_ok && in_word.func == FUNC_KEY && in_word.last &&
        32'(in_word.byte_position) < 32'(MAX_KEY_LEN)) begin
      klen_mem[IW'(in_word.entry_index)] <= LW'(32'(in_word.byte_position) + 32'd1);
    end
    klen_q <= klen_mem[IW'(slot_r)];
  end

  always_ff @(posedge clk) begin
    if (accept && is_lookup && lookup_length < LW'(MAX_KEY_LEN)) begin
      buf_mem[lookup_length[BW-1:0]] <= in_word.key_byte;
    end
    buf_q <= buf_mem[idx[BW-1:0]];
  end

  // Output register: hold until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_DONE && (!out_valid || out_ready)) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && (!out_valid || out_ready)) begin
      out_word.found    <= found_r;
      out_word.slot     <= found_r ? slot_r : 8'd0;
      out_word.key_hash <= running_hash;
      out_word.too_long <= overflow_flag;
    end
  end

endmodule

[tb/phnl_lookup_checker.sv]
// ----------------------------------------------------------------------------
// phnl_lookup_checker
// Watches the word channels of the name lookup block, keeps its own copy of
// the tables and lookup state, predicts each result word and compares it.
// ----------------------------------------------------------------------------
module phnl_lookup_checker (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic                 in_ready,
  input  phnl_pkg::in_word_t   in_word,
  input  logic                 out_valid,
  input  logic                 out_ready,
  input  phnl_pkg::out_word_t  out_word,
  input  logic                 cfg_we,
  input  logic [8:0]           cfg_wdata,
  output int                   errors,
  output int                   pending
);
  import phnl_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH   = 256;
  localparam int KEY_MAX = 64;
  localparam logic [63:0] FNV_START = 64'h0100_0193;

  logic [31:0] disp_tab [DEPTH];
  logic [7:0]  slot_tab [DEPTH];
  logic [7:0]  key_mem  [DEPTH][KEY_MAX];
  logic [6:0]  key_len  [DEPTH];
  logic [7:0]  name_buf [KEY_MAX];
  logic [63:0] name_hash;
  logic [6:0]  name_len;
  logic        name_ovf;
  logic [8:0]  size_reg;
  out_word_t   result_q [$];

  function automatic logic [63:0] fnv_step(logic [63:0] h, logic [7:0] b);
    return (h ^ {{56{b[7]}}, b}) * FNV_START;
  endfunction

  function automatic logic [63:0] modulus();
    if (size_reg == 0) return 64'd1;
    if (size_reg > DEPTH) return 64'(DEPTH);
    return {55'd0, size_reg};
  endfunction

  // C-string style compare of the stored key against the collected name
  function automatic bit names_match(logic [7:0] s);
    int la;
    int lb;
    logic [7:0] a;
    logic [7:0] b;
    la = key_len[s];
    lb = name_len;
    for (int i = 0; i <= ((la > lb) ? la : lb); i++) begin
      a = (i < la && i < KEY_MAX) ? key_mem[s][i] : 8'd0;
      b = (i < lb && i < KEY_MAX) ? name_buf[i] : 8'd0;
      if (a != b) return 0;
      if (a == 0) return 1;
    end
    return 1;
  endfunction

  function automatic out_word_t resolve_name();
    out_word_t r;
    logic [63:0] n;
    logic [63:0] h2;
    logic [31:0] d;
    logic [31:0] di;
    logic [7:0]  s;
    bit          ok;
    n  = modulus();
    ok = 0;
    s  = 0;
    r  = '0;
    r.key_hash = name_hash;
    r.too_long = name_ovf;
    if (!name_ovf) begin
      d = disp_tab[name_hash % n];
      if (d[31]) begin
        di = ~d & 32'h7FFF_FFFF;
        if (di < DEPTH) begin
          s  = slot_tab[di];
          ok = 1;
        end
      end else begin
        h2 = (d == 0) ? FNV_START : {32'd0, d};
        for (int i = 0; i < name_len; i++) h2 = fnv_step(h2, name_buf[i]);
        s  = slot_tab[h2 % n];
        ok = 1;
      end
      if (ok && names_match(s)) begin
        r.found = 1'b1;
        r.slot  = s;
      end
    end
    return r;
  endfunction

  always @(posedge clk) begin
    out_word_t exp_w;
    if (rst) begin
      size_reg  <= 9'd1;
      name_hash = FNV_START;
      name_len  = '0;
      name_ovf  = 1'b0;
      result_q.delete();
      errors    <= 0;
      pending   <= 0;
    end else begin
      if (cfg_we) size_reg <= cfg_wdata;
      if (in_valid && in_ready) begin
        case (func_t'(in_word.func))
          FUNC_DISP: disp_tab[in_word.entry_index] = in_word.displacement;
          FUNC_SLOT: slot_tab[in_word.entry_index] = in_word.slot_value;
          FUNC_KEY: begin
            key_mem[in_word.entry_index][in_word.byte_position] = in_word.key_byte;
            if (in_word.last) key_len[in_word.entry_index] = in_word.byte_position + 7'd1;
          end
          FUNC_LOOKUP: begin
            name_hash = fnv_step(name_hash, in_word.key_byte);
            if (name_len < KEY_MAX) begin
              name_buf[name_len] = in_word.key_byte;
              name_len = name_len + 7'd1;
            end else begin
              name_ovf = 1'b1;
            end
            if (in_word.last) begin
              result_q.push_back(resolve_name());
              name_hash = FNV_START;
              name_len  = '0;
              name_ovf  = 1'b0;
            end
          end
        endcase
      end
      if (out_valid && out_ready) begin
        if (result_q.size() == 0) begin
          if (errors < 10) $display("unexpected result word %p", out_word);
          errors <= errors + 1;
        end else begin
          exp_w = result_q.pop_front();
          if (exp_w.found !== out_word.found || exp_w.slot !== out_word.slot ||
              exp_w.key_hash !== out_word.key_hash ||
              exp_w.too_long !== out_word.too_long) begin
            if (errors < 10) $display("mismatch: expected %p, got %p", exp_w, out_word);
            errors <= errors + 1;
          end
        end
      end
      pending <= result_q.size();
    end
  end

endmodule

[tb/tb_perfect_hash_name_lookup_top.sv]
// ----------------------------------------------------------------------------
// tb_perfect_hash_name_lookup_top
// Loads full tables, then runs lookup phases over several table sizes with
// bursty input, a stalling receiver and one long output hold-off.
// ----------------------------------------------------------------------------
module tb_perfect_hash_name_lookup_top;
  import phnl_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [63:0] FNV_START = 64'h0100_0193;
  localparam int SETTLE = 700;
  // keys live in the low entries and in entry 255; every slot map value points at a stored key
  localparam int KEYS = 32;

  logic       clk;
  logic       rst;
  logic       in_valid;
  logic       in_ready;
  in_word_t   in_word;
  logic       out_valid;
  logic       out_ready;
  out_word_t  out_word;
  logic       cfg_we;
  logic [8:0] cfg_wdata;
  int         errors;
  int         pending;

  // shadow of stored keys and table size, used to build lookups and stray key writes
  logic [7:0] stored_key [256][$];
  logic [8:0] cur_size;
  int         burst_left;
  int         words_sent;
  bit         hold_req;

  perfect_hash_name_lookup_top u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_word(in_word),
    .out_valid(out_valid), .out_ready(out_ready), .out_word(out_word),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  phnl_lookup_checker u_chk (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_word(in_word),
    .out_valid(out_valid), .out_ready(out_ready), .out_word(out_word),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .errors(errors), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Limit the run: well above the slowest legal pass through all phases.
  initial begin
    #2_000_000;
    $display("FAIL");
    $finish;
  end

  // Receiver: switch stall pattern every stretch; serve one long hold-off on request.
  initial begin
    int mode;
    bit held;
    out_ready = 1'b0;
    held = 0;
    forever begin
      mode = $urandom_range(0, 2);
      if (hold_req && !held) begin
        // hold off long enough for the block to back up its input
        out_ready <= 1'b0;
        repeat (900) @(negedge clk);
        held = 1;
      end
      repeat ($urandom_range(10, 80)) begin
        @(negedge clk);
        case (mode)
          0:       out_ready <= 1'b1;
          1:       out_ready <= ($urandom_range(0, 3) != 0);
          default: out_ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  function automatic logic [63:0] name_hash(logic [63:0] h0, logic [7:0] nm[$]);
    logic [63:0] h;
    h = h0;
    foreach (nm[i]) h = (h ^ {{56{nm[i][7]}}, nm[i]}) * FNV_START;
    return h;
  endfunction

  function automatic logic [63:0] eff_size();
    if (cur_size == 0) return 64'd1;
    if (cur_size > 256) return 64'd256;
    return {55'd0, cur_size};
  endfunction

  // Offer one word; called at a falling edge, returns at a falling edge.
  task automatic send_word(input in_word_t w);
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                               : $urandom_range(1, 8);
    end
    burst_left--;
    in_valid <= 1'b1;
    in_word  <= w;
    do @(posedge clk); while (!in_ready);
    words_sent++;
    @(negedge clk);
  endtask

  // Fill unused fields with noise so every bit toggles.
  function automatic in_word_t noise_word(func_t f);
    in_word_t w;
    w.func          = f;
    w.entry_index   = 8'($urandom);
    w.byte_position = 6'($urandom);
    w.displacement  = $urandom;
    w.slot_value    = 8'($urandom);
    w.key_byte      = 8'($urandom);
    w.last          = 1'($urandom);
    return w;
  endfunction

  task automatic write_disp(input logic [7:0] e, input logic [31:0] d);
    in_word_t w;
    w = noise_word(FUNC_DISP);
    w.entry_index  = e;
    w.displacement = d;
    send_word(w);
  endtask

  task automatic write_slot(input logic [7:0] e, input logic [7:0] s);
    in_word_t w;
    w = noise_word(FUNC_SLOT);
    w.entry_index = e;
    w.slot_value  = s;
    send_word(w);
  endtask

  task automatic store_key(input logic [7:0] e, input logic [7:0] nm[$]);
    in_word_t w;
    foreach (nm[i]) begin
      w = noise_word(FUNC_KEY);
      w.entry_index   = e;
      w.byte_position = 6'(i);
      w.key_byte      = nm[i];
      w.last          = (i == nm.size() - 1);
      send_word(w);
    end
    stored_key[e] = nm;
  endtask

  task automatic lookup_name(input logic [7:0] nm[$]);
    in_word_t w;
    foreach (nm[i]) begin
      w = noise_word(FUNC_LOOKUP);
      w.key_byte = nm[i];
      w.last     = (i == nm.size() - 1);
      send_word(w);
    end
  endtask

  // Point the name at slot s: direct map entry, rehash, default rehash, or a
  // direct index far out of range.
  task automatic route_name(input logic [7:0] nm[$], input logic [7:0] s, input int how);
    logic [63:0] n;
    logic [7:0]  idx;
    logic [7:0]  j;
    logic [31:0] d;
    n   = eff_size();
    idx = 8'(name_hash(FNV_START, nm) % n);
    case (how)
      0: begin
        j = 8'($urandom);
        write_slot(j, s);
        write_disp(idx, ~{24'd0, j});
      end
      1, 2: begin
        d = (how == 2) ? 32'd0 : ($urandom & 32'h7FFF_FFFF);
        if (how == 1 && d == 0) d = 32'd1;
        write_slot(8'(name_hash((d == 0) ? FNV_START : {32'd0, d}, nm) % n), s);
        write_disp(idx, d);
      end
      default: write_disp(idx, ($urandom | 32'h8000_0000) & 32'hBFFF_FFFF);
    endcase
  endtask

  function automatic void rand_name(output logic [7:0] nm[$], input int len);
    nm = {};
    repeat (len) nm.push_back(($urandom_range(0, 9) == 0) ? 8'd0 : 8'($urandom));
  endfunction

  task automatic set_size(input logic [8:0] v);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    cur_size  = v;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Wait out every result, then the block's longest lookup time.
  task automatic drain();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic random_phase(input int count);
    logic [7:0] nm[$];
    logic [7:0] s;
    int kind;
    int stop_at;
    stop_at = words_sent + count;
    while (words_sent < stop_at) begin
      kind = $urandom_range(0, 99);
      s    = 8'($urandom_range(0, KEYS - 1));
      if (kind < 55) begin
        // well-formed lookup of a stored key, sometimes with one byte changed
        nm = stored_key[s];
        route_name(nm, s, $urandom_range(0, 3));
        if ($urandom_range(0, 9) == 0) nm[$urandom_range(0, nm.size() - 1)] ^= 8'h01;
        lookup_name(nm);
      end else if (kind < 65) begin
        rand_name(nm, $urandom_range(1, 6));
        lookup_name(nm);
      end else if (kind < 68) begin
        rand_name(nm, $urandom_range(65, 70));
        lookup_name(nm);
      end else if (kind < 80) begin
        rand_name(nm, ($urandom_range(0, 15) == 0) ? 64 : $urandom_range(1, 8));
        store_key(s, nm);
      end else begin
        // stray table writes; key bytes only without closing a key
        case ($urandom_range(0, 2))
          0: write_disp(8'($urandom), $urandom);
          1: write_slot(8'($urandom), 8'($urandom_range(0, KEYS - 1)));
          default: begin
            nm = stored_key[s];
            send_word('{func: FUNC_KEY, entry_index: s,
                        byte_position: 6'($urandom_range(0, nm.size() - 1)),
                        displacement: $urandom, slot_value: 8'($urandom),
                        key_byte: 8'($urandom), last: 1'b0});
          end
        endcase
      end
    end
  endtask

  initial begin
    logic [7:0] nm[$];
    logic [8:0] sizes[$];
    rst        = 1'b1;
    in_valid   = 1'b0;
    in_word    = '0;
    cfg_we     = 1'b0;
    cfg_wdata  = '0;
    cur_size   = 9'd1;
    burst_left = 0;
    words_sent = 0;
    hold_req   = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Load every table entry and every key a slot can point at.
    set_size(9'd256);
    for (int e = 0; e < 256; e++) begin
      write_disp(8'(e), $urandom);
      write_slot(8'(e), 8'($urandom_range(0, KEYS - 1)));
      if (e < KEYS) begin
        rand_name(nm, $urandom_range(1, 4));
        store_key(8'(e), nm);
      end
    end

    // Directed: byte extremes, each route, bad direct index, long name, miss.
    nm = '{8'hFF};             store_key(8'd255, nm); route_name(nm, 8'd255, 0);
    lookup_name(nm);
    nm = '{8'h80, 8'h7F, 8'h00}; store_key(8'd0, nm); route_name(nm, 8'd0, 1);
    lookup_name(nm);
    nm = '{8'h41, 8'h42};      store_key(8'd7, nm);   route_name(nm, 8'd7, 2);
    lookup_name(nm);
    route_name(nm, 8'd7, 3);   lookup_name(nm);
    write_slot(8'd0, 8'd7);    write_disp(8'(name_hash(FNV_START, nm) % 256), 32'hFFFF_FFFF);
    lookup_name(nm);
    nm = '{8'h41};             lookup_name(nm);
    rand_name(nm, 65);         lookup_name(nm);
    drain();

    // Sizes include the extremes and the out-of-range codes.
    sizes = '{9'd1, 9'd256, 9'd0, 9'd511, 9'd2, 9'd255, 9'd37, 9'd128};
    foreach (sizes[p]) begin
      set_size(sizes[p]);
      if (p == 2) begin
        // keep lookups coming while the receiver holds off
        hold_req = 1;
        repeat (3) begin
          rand_name(nm, 2);
          lookup_name(nm);
        end
      end
      random_phase(25);
      drain();
    end

    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
